[rtl/core/srwc_pkg.sv]
// Shared types, codes and sequence helpers for the selective-repeat window controller.
package srwc_pkg;

   localparam int WINDOW_SLOTS = 8;
   localparam int SEQ_MODULUS  = 16;
   localparam int MAX_RESULTS  = 20;

   localparam int SEQ_W  = 4;
   localparam int SLOT_W = 3;
   localparam int CMD_W  = 3;
   localparam int ACT_W  = 3;
   localparam int FT_W   = 2;
   localparam int OUT_W  = $clog2(WINDOW_SLOTS + 1);
   localparam int CNT_W  = $clog2(MAX_RESULTS + 1);

   localparam logic [ACT_W-1:0] ACT_HOST    = 3'd0;
   localparam logic [ACT_W-1:0] ACT_LINK    = 3'd1;
   localparam logic [ACT_W-1:0] ACT_FRAME   = 3'd2;
   localparam logic [ACT_W-1:0] ACT_ACK_TO  = 3'd3;
   localparam logic [ACT_W-1:0] ACT_DATA_TO = 3'd4;

   localparam logic [FT_W-1:0] FT_DATA = 2'd0;
   localparam logic [FT_W-1:0] FT_ACK  = 2'd1;
   localparam logic [FT_W-1:0] FT_NAK  = 2'd2;

   typedef enum logic [CMD_W-1:0] {
      CMD_STATUS     = 3'd0,
      CMD_SEND_DATA  = 3'd1,
      CMD_SEND_ACK   = 3'd2,
      CMD_SEND_NAK   = 3'd3,
      CMD_STORE      = 3'd4,
      CMD_DELIVER    = 3'd5,
      CMD_START_ACKT = 3'd6,
      CMD_STOP_DATAT = 3'd7
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_STORE,
      ST_DELIVER,
      ST_NAK_RESEND,
      ST_ACK_WALK,
      ST_STATUS
   } st_type;

   typedef struct packed {
      cmd_type              command;
      logic [SEQ_W-1:0]     seq;
      logic [SEQ_W-1:0]     ack;
      logic [SLOT_W-1:0]    slot;
      logic                 network_enable;
      logic                 last;
   } rsp_word_type;

   function automatic logic [SEQ_W-1:0] next_seq(input logic [SEQ_W-1:0] s);
      return (s == SEQ_W'(SEQ_MODULUS - 1)) ? '0 : s + 1'b1;
   endfunction

   function automatic logic [SEQ_W-1:0] prev_seq(input logic [SEQ_W-1:0] s);
      return (s == '0) ? SEQ_W'(SEQ_MODULUS - 1) : s - 1'b1;
   endfunction

   function automatic logic [SLOT_W-1:0] slot_of(input logic [SEQ_W-1:0] s);
      return SLOT_W'(s % WINDOW_SLOTS);
   endfunction

endpackage

[rtl/core/srwc_window_unit.sv]
// Shared circular window test: lo <= probe < hi modulo the sequence space.
module srwc_window_unit (
   input  logic [srwc_pkg::SEQ_W-1:0] lo,
   input  logic [srwc_pkg::SEQ_W-1:0] probe,
   input  logic [srwc_pkg::SEQ_W-1:0] hi,
   output logic                       hit
);

   logic lo_le_probe;
   logic probe_lt_hi;
   logic hi_lt_lo;

   assign lo_le_probe = (lo <= probe);
   assign probe_lt_hi = (probe < hi);
   assign hi_lt_lo    = (hi < lo);

   assign hit = (lo_le_probe && probe_lt_hi) || (hi_lt_lo && lo_le_probe) ||
                (probe_lt_hi && hi_lt_lo);

endmodule

[rtl/core/srwc_rsp_reg.sv]
// Output register holding one result word until the consumer takes it.
module srwc_rsp_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  srwc_pkg::rsp_word_type word_in,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output srwc_pkg::rsp_word_type word_out,
   output logic                   free
);

   logic                   valid_ff;
   logic                   valid_in;
   srwc_pkg::rsp_word_type word_ff;

   assign free     = !valid_ff || rsp_ready;
   assign valid_in = load ? 1'b1 : (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= word_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign word_out  = word_ff;

endmodule

[rtl/core/selective_repeat_window_control.sv]
// Top level: event sequencer and window state of the selective-repeat controller.
// Throughput: one result word per cycle while rsp_ready is high; the sequencer steps the
// delivery and acknowledge walks one sequence number per cycle while the output register
// is free, and takes no new event until it returns to idle.
// Reset: synchronous; window edges, counts and marks return to their initial values.
module selective_repeat_window_control (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [srwc_pkg::ACT_W-1:0]  req_action,
   input  logic                        req_frame_good,
   input  logic [srwc_pkg::FT_W-1:0]   req_frame_type,
   input  logic [srwc_pkg::SEQ_W-1:0]  req_rx_seq,
   input  logic [srwc_pkg::SEQ_W-1:0]  req_rx_ack,
   input  logic [srwc_pkg::SEQ_W-1:0]  req_expired_seq,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [srwc_pkg::CMD_W-1:0]  rsp_command,
   output logic [srwc_pkg::SEQ_W-1:0]  rsp_seq_out,
   output logic [srwc_pkg::SEQ_W-1:0]  rsp_ack_out,
   output logic [srwc_pkg::SLOT_W-1:0] rsp_slot_out,
   output logic                        rsp_network_enable,
   output logic                        rsp_last
);

   srwc_pkg::st_type state_ff, state_in;

   logic [srwc_pkg::ACT_W-1:0]  act_ff;
   logic                        good_ff;
   logic [srwc_pkg::FT_W-1:0]   ft_ff;
   logic [srwc_pkg::SEQ_W-1:0]  rseq_ff;
   logic [srwc_pkg::SEQ_W-1:0]  rack_ff;
   logic [srwc_pkg::SEQ_W-1:0]  eseq_ff;

   logic [srwc_pkg::SEQ_W-1:0]  aes_ff, aes_in;
   logic [srwc_pkg::SEQ_W-1:0]  nss_ff, nss_in;
   logic [srwc_pkg::SEQ_W-1:0]  rexp_ff, rexp_in;
   logic [srwc_pkg::SEQ_W-1:0]  rwe_ff, rwe_in;
   logic [srwc_pkg::OUT_W-1:0]  outst_ff, outst_in;
   logic                        nak_ok_ff, nak_ok_in;
   logic                        link_ff, link_in;
   logic [srwc_pkg::WINDOW_SLOTS-1:0] marks_ff, marks_in;
   logic                        any_ff, any_in;
   logic [srwc_pkg::CNT_W-1:0]  cnt_ff, cnt_in;

   logic                        accept;
   logic                        advance;
   logic                        free;
   logic                        emit;
   logic                        load;
   srwc_pkg::rsp_word_type      word;
   srwc_pkg::rsp_word_type      word_out;

   logic [srwc_pkg::SEQ_W-1:0]  win_lo, win_probe, win_hi;
   logic                        win_hit;

   logic                        room;
   logic                        rseq_mark;
   logic                        rexp_mark;

   assign req_ready = (state_ff == srwc_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign advance   = free && (state_ff != srwc_pkg::ST_IDLE);

   assign room      = (outst_ff < srwc_pkg::OUT_W'(srwc_pkg::WINDOW_SLOTS));
   assign rseq_mark = marks_ff[srwc_pkg::slot_of(rseq_ff)];
   assign rexp_mark = marks_ff[srwc_pkg::slot_of(rexp_ff)];

   srwc_window_unit u_win (
      .lo    (win_lo),
      .probe (win_probe),
      .hi    (win_hi),
      .hit   (win_hit)
   );

   // operand select for the shared window unit
   always_comb begin
      win_lo    = aes_ff;
      win_probe = rack_ff;
      win_hi    = nss_ff;
      case (state_ff)
         srwc_pkg::ST_STORE: begin
            win_lo    = rexp_ff;
            win_probe = rseq_ff;
            win_hi    = rwe_ff;
         end
         srwc_pkg::ST_NAK_RESEND: begin
            win_probe = srwc_pkg::next_seq(rack_ff);
         end
         default: begin
            win_lo = aes_ff;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         srwc_pkg::ST_IDLE: begin
            if (accept) state_in = srwc_pkg::ST_DECIDE;
         end
         srwc_pkg::ST_DECIDE: begin
            if (advance) begin
               state_in = srwc_pkg::ST_STATUS;
               if (act_ff == srwc_pkg::ACT_FRAME && good_ff) begin
                  if (ft_ff == srwc_pkg::FT_DATA) begin
                     state_in = srwc_pkg::ST_STORE;
                  end else if (ft_ff == srwc_pkg::FT_NAK) begin
                     state_in = srwc_pkg::ST_NAK_RESEND;
                  end else begin
                     state_in = srwc_pkg::ST_ACK_WALK;
                  end
               end
            end
         end
         srwc_pkg::ST_STORE: begin
            if (advance) begin
               state_in = (win_hit && !rseq_mark) ? srwc_pkg::ST_DELIVER
                                                  : srwc_pkg::ST_ACK_WALK;
            end
         end
         srwc_pkg::ST_DELIVER: begin
            if (advance && !rexp_mark) state_in = srwc_pkg::ST_ACK_WALK;
         end
         srwc_pkg::ST_NAK_RESEND: begin
            if (advance) state_in = srwc_pkg::ST_ACK_WALK;
         end
         srwc_pkg::ST_ACK_WALK: begin
            if (advance && !(outst_ff != '0 && win_hit)) state_in = srwc_pkg::ST_STATUS;
         end
         srwc_pkg::ST_STATUS: begin
            if (advance) state_in = srwc_pkg::ST_IDLE;
         end
         default: begin
            state_in = srwc_pkg::ST_IDLE;
         end
      endcase
   end

   // result words and window state updates
   always_comb begin
      aes_in    = aes_ff;
      nss_in    = nss_ff;
      rexp_in   = rexp_ff;
      rwe_in    = rwe_ff;
      outst_in  = outst_ff;
      nak_ok_in = nak_ok_ff;
      link_in   = link_ff;
      marks_in  = marks_ff;
      any_in    = any_ff;
      cnt_in    = cnt_ff;
      emit      = 1'b0;
      word      = '0;
      word.command = srwc_pkg::CMD_STATUS;

      if (accept) begin
         any_in = 1'b0;
         cnt_in = '0;
      end

      if (advance) begin
         case (state_ff)
            srwc_pkg::ST_DECIDE: begin
               case (act_ff)
                  srwc_pkg::ACT_HOST: begin
                     if (room) begin
                        emit         = 1'b1;
                        word.command = srwc_pkg::CMD_SEND_DATA;
                        word.seq     = nss_ff;
                        word.ack     = srwc_pkg::prev_seq(rexp_ff);
                        word.slot    = srwc_pkg::slot_of(nss_ff);
                        outst_in     = outst_ff + 1'b1;
                        nss_in       = srwc_pkg::next_seq(nss_ff);
                        link_in      = 1'b0;
                     end
                  end
                  srwc_pkg::ACT_LINK: begin
                     link_in = 1'b1;
                  end
                  srwc_pkg::ACT_FRAME: begin
                     if (!good_ff) begin
                        if (nak_ok_ff) begin
                           emit         = 1'b1;
                           word.command = srwc_pkg::CMD_SEND_NAK;
                           word.ack     = srwc_pkg::prev_seq(rexp_ff);
                           nak_ok_in    = 1'b0;
                           link_in      = 1'b0;
                        end
                     end else if (ft_ff == srwc_pkg::FT_DATA) begin
                        emit = 1'b1;
                        if (rseq_ff != rexp_ff && nak_ok_ff) begin
                           word.command = srwc_pkg::CMD_SEND_NAK;
                           word.ack     = srwc_pkg::prev_seq(rexp_ff);
                           nak_ok_in    = 1'b0;
                           link_in      = 1'b0;
                        end else begin
                           word.command = srwc_pkg::CMD_START_ACKT;
                        end
                     end
                  end
                  srwc_pkg::ACT_ACK_TO: begin
                     emit         = 1'b1;
                     word.command = srwc_pkg::CMD_SEND_ACK;
                     word.ack     = srwc_pkg::prev_seq(rexp_ff);
                     link_in      = 1'b0;
                  end
                  srwc_pkg::ACT_DATA_TO: begin
                     emit         = 1'b1;
                     word.command = srwc_pkg::CMD_SEND_DATA;
                     word.seq     = eseq_ff;
                     word.ack     = srwc_pkg::prev_seq(rexp_ff);
                     word.slot    = srwc_pkg::slot_of(eseq_ff);
                     link_in      = 1'b0;
                  end
                  default: begin
                     emit = 1'b0;
                  end
               endcase
            end
            srwc_pkg::ST_STORE: begin
               if (win_hit && !rseq_mark) begin
                  emit         = 1'b1;
                  word.command = srwc_pkg::CMD_STORE;
                  word.seq     = rseq_ff;
                  word.slot    = srwc_pkg::slot_of(rseq_ff);
                  marks_in[srwc_pkg::slot_of(rseq_ff)] = 1'b1;
               end
            end
            srwc_pkg::ST_DELIVER: begin
               if (rexp_mark) begin
                  emit         = 1'b1;
                  word.command = srwc_pkg::CMD_DELIVER;
                  word.seq     = rexp_ff;
                  word.slot    = srwc_pkg::slot_of(rexp_ff);
                  nak_ok_in    = 1'b1;
                  marks_in[srwc_pkg::slot_of(rexp_ff)] = 1'b0;
                  rexp_in      = srwc_pkg::next_seq(rexp_ff);
                  rwe_in       = srwc_pkg::next_seq(rwe_ff);
                  any_in       = 1'b1;
               end else if (any_ff) begin
                  emit         = 1'b1;
                  word.command = srwc_pkg::CMD_START_ACKT;
               end
            end
            srwc_pkg::ST_NAK_RESEND: begin
               if (win_hit) begin
                  emit         = 1'b1;
                  word.command = srwc_pkg::CMD_SEND_DATA;
                  word.seq     = win_probe;
                  word.ack     = srwc_pkg::prev_seq(rexp_ff);
                  word.slot    = srwc_pkg::slot_of(win_probe);
                  link_in      = 1'b0;
               end
            end
            srwc_pkg::ST_ACK_WALK: begin
               if (outst_ff != '0 && win_hit) begin
                  emit         = 1'b1;
                  word.command = srwc_pkg::CMD_STOP_DATAT;
                  word.seq     = aes_ff;
                  word.slot    = srwc_pkg::slot_of(aes_ff);
                  outst_in     = outst_ff - 1'b1;
                  aes_in       = srwc_pkg::next_seq(aes_ff);
               end
            end
            srwc_pkg::ST_STATUS: begin
               emit                = 1'b1;
               word.command        = srwc_pkg::CMD_STATUS;
               word.network_enable = room && link_ff;
               word.last           = 1'b1;
            end
            default: begin
               emit = 1'b0;
            end
         endcase
      end

      // drop non-status words beyond the per-event limit
      load = emit && (word.last || cnt_ff < srwc_pkg::CNT_W'(srwc_pkg::MAX_RESULTS - 1));
      if (load && !word.last) cnt_in = cnt_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= srwc_pkg::ST_IDLE;
         aes_ff    <= '0;
         nss_ff    <= '0;
         rexp_ff   <= '0;
         rwe_ff    <= srwc_pkg::SEQ_W'(srwc_pkg::WINDOW_SLOTS % srwc_pkg::SEQ_MODULUS);
         outst_ff  <= '0;
         nak_ok_ff <= 1'b1;
         link_ff   <= 1'b0;
         marks_ff  <= '0;
         any_ff    <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         aes_ff    <= aes_in;
         nss_ff    <= nss_in;
         rexp_ff   <= rexp_in;
         rwe_ff    <= rwe_in;
         outst_ff  <= outst_in;
         nak_ok_ff <= nak_ok_in;
         link_ff   <= link_in;
         marks_ff  <= marks_in;
         any_ff    <= any_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff  <= req_action;
         good_ff <= req_frame_good;
         ft_ff   <= req_frame_type;
         rseq_ff <= req_rx_seq;
         rack_ff <= req_rx_ack;
         eseq_ff <= req_expired_seq;
      end
   end

   srwc_rsp_reg u_rsp (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .word_in   (word),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .word_out  (word_out),
      .free      (free)
   );

   assign rsp_command        = word_out.command;
   assign rsp_seq_out        = word_out.seq;
   assign rsp_ack_out        = word_out.ack;
   assign rsp_slot_out       = word_out.slot;
   assign rsp_network_enable = word_out.network_enable;
   assign rsp_last           = word_out.last;

endmodule
